@@ src/bsf_pkg.sv @@
// Shared types and constants for the byte stuffing framer.
// Used by every module in src; no dependencies.
`default_nettype none
package bsf_pkg;

	localparam int unsigned RUN_DEPTH = 4;
	localparam int unsigned RUN_IDX_W = 2;

	localparam logic [7:0] START_CODE_RST  = 8'h01;
	localparam logic [7:0] ESCAPE_CODE_RST = 8'h10;
	localparam logic [7:0] END_CODE_RST    = 8'h03;

	typedef enum logic [1:0] {
		REG_START  = 2'd0,
		REG_ESCAPE = 2'd1,
		REG_END    = 2'd2
	} bsf_reg_t;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       first_byte;
		logic       final_byte;
	} bsf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
	} bsf_out_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] escape_code;
		logic [7:0] end_code;
	} bsf_codes_t;

	typedef struct packed {
		logic [RUN_DEPTH-1:0][7:0] bytes;
		logic [RUN_IDX_W-1:0]      last_idx;
		logic                      nonempty;
	} bsf_run_t;

endpackage
`default_nettype wire

@@ src/bsf_cfg_regs.sv @@
// Code registers for start, escape and end markers.
// Depends on bsf_pkg.
`default_nettype none
module bsf_cfg_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	output bsf_pkg::bsf_codes_t     codes
);

	bsf_pkg::bsf_codes_t codes_q;

	assign cfg_ready = 1'b1;
	assign codes     = codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.start_code  <= bsf_pkg::START_CODE_RST;
			codes_q.escape_code <= bsf_pkg::ESCAPE_CODE_RST;
			codes_q.end_code    <= bsf_pkg::END_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (bsf_pkg::bsf_reg_t'(cfg_index))
				bsf_pkg::REG_START:  codes_q.start_code  <= cfg_data;
				bsf_pkg::REG_ESCAPE: codes_q.escape_code <= cfg_data;
				bsf_pkg::REG_END:    codes_q.end_code    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ src/bsf_expand.sv @@
// Input stage register, escape flag and run expansion of one item.
// Depends on bsf_pkg.
`default_nettype none
module bsf_expand (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire bsf_pkg::bsf_in_t    in_data,
	input  wire bsf_pkg::bsf_codes_t codes,
	input  wire logic                ser_ready,
	output logic                     run_push,
	output bsf_pkg::bsf_run_t        run
);

	bsf_pkg::bsf_in_t item_s1;
	logic             valid_s1;
	logic             pending_q;
	logic             pending_d;
	logic             take;
	logic             hit_start;
	logic             hit_esc;
	logic             hit_end;

	assign hit_start = (item_s1.data_byte == codes.start_code);
	assign hit_esc   = (item_s1.data_byte == codes.escape_code);
	assign hit_end   = (item_s1.data_byte == codes.end_code);

	always_comb begin
		logic [2:0] n;
		logic [2:0] n1;
		run       = '0;
		pending_d = pending_q;
		n         = 3'd0;
		n1        = 3'd0;
		if (item_s1.mode == bsf_pkg::MODE_ENCODE) begin
			if (item_s1.first_byte) begin
				run.bytes[0] = codes.start_code;
				n            = 3'd1;
			end
			if (hit_start || hit_esc || hit_end) begin
				n1                 = n + 3'd1;
				run.bytes[n[1:0]]  = codes.escape_code;
				run.bytes[n1[1:0]] = ~item_s1.data_byte;
				n                  = n + 3'd2;
			end else begin
				run.bytes[n[1:0]] = item_s1.data_byte;
				n                 = n + 3'd1;
			end
			if (item_s1.final_byte) begin
				run.bytes[n[1:0]] = codes.end_code;
				n                 = n + 3'd1;
			end
		end else begin
			if (pending_q) begin
				pending_d    = 1'b0;
				run.bytes[0] = ~item_s1.data_byte;
				n            = 3'd1;
			end else if (hit_start || hit_end) begin
				n = 3'd0;
			end else if (hit_esc) begin
				pending_d = 1'b1;
			end else begin
				run.bytes[0] = item_s1.data_byte;
				n            = 3'd1;
			end
		end
		n1           = n - 3'd1;
		run.last_idx = n1[bsf_pkg::RUN_IDX_W-1:0];
		run.nonempty = (n != 3'd0);
	end

	assign take     = valid_s1 && (!run.nonempty || ser_ready);
	assign run_push = take && run.nonempty;
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
			if (take && (item_s1.mode == bsf_pkg::MODE_DECODE)) begin
				pending_q <= pending_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

`ifndef SYNTHESIS
	a_pending_on_decode_take: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pending_q) |-> $past(take && (item_s1.mode == bsf_pkg::MODE_DECODE)))
		else $error("escape flag changed without a decode transaction");
	a_no_push_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		run_push |-> ser_ready && valid_s1)
		else $error("run pushed into a busy serializer");
`endif

endmodule
`default_nettype wire

@@ src/bsf_serializer.sv @@
// Run register that emits one byte of the current run per transaction.
// Depends on bsf_pkg.
`default_nettype none
module bsf_serializer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              run_push,
	input  wire bsf_pkg::bsf_run_t run,
	output logic                   ser_ready,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output bsf_pkg::bsf_out_t      out_data
);

	bsf_pkg::bsf_run_t             run_q;
	logic                          run_valid_q;
	logic [bsf_pkg::RUN_IDX_W-1:0] idx_q;
	logic                          out_take;

	assign out_valid         = run_valid_q;
	assign out_data.out_byte = run_q.bytes[idx_q];
	assign out_data.run_end  = (idx_q == run_q.last_idx);
	assign out_take          = out_valid && !out_stall;
	assign ser_ready         = !run_valid_q || (out_take && out_data.run_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (run_push) begin
			run_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (out_take && out_data.run_end) begin
			run_valid_q <= 1'b0;
		end else if (out_take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_push) begin
			run_q <= run;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> (idx_q <= run_q.last_idx))
		else $error("byte index beyond end of run");
	a_more_after_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !out_data.run_end |=> out_valid && (idx_q == $past(idx_q) + 1'b1))
		else $error("run cut short");
`endif

endmodule
`default_nettype wire

@@ src/byte_stuffing_framer_core.sv @@
// Top level of the byte stuffing framer: code registers, expansion stage, serializer.
// Depends on bsf_pkg, bsf_cfg_regs, bsf_expand and bsf_serializer.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  bsf_in_t   (mode, data_byte, first/final flags)
//   out      source     out_valid/out_stall bsf_out_t (out_byte, run_end)
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction per cycle on each side unless stalled; an item yields 0 to 4 output
// bytes, so encode with start, escape and end yields 4 bytes, sent one per transaction.
// An input transaction passes the input stage register and the run register before output.
// Reset restores the default codes and clears the escape flag and all valid state.
// A stalled output holds the run; the input stage then fills and stalls the input.
`default_nettype none
module byte_stuffing_framer_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire bsf_pkg::bsf_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output bsf_pkg::bsf_out_t      out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);

	bsf_pkg::bsf_codes_t codes;
	bsf_pkg::bsf_run_t   run;
	logic                run_push;
	logic                ser_ready;

	bsf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	bsf_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.codes     (codes),
		.ser_ready (ser_ready),
		.run_push  (run_push),
		.run       (run)
	);

	bsf_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_push  (run_push),
		.run       (run),
		.ser_ready (ser_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
